// File: rtl/miq_pkg.sv
package miq_pkg;

  localparam int unsigned DEF_CAPACITY = 1024;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned STAT_W   = 2;
  localparam int unsigned ECOUNT_W = 11;

  typedef logic [CMD_W-1:0]           cmd_t;
  typedef logic signed [DATA_W-1:0]   data_t;
  typedef logic [STAT_W-1:0]          stat_t;
  typedef logic [ECOUNT_W-1:0]        ecount_t;

  // command codes
  localparam cmd_t CMD_PUSH   = 2'd0;
  localparam cmd_t CMD_INSERT = 2'd1;
  localparam cmd_t CMD_POP    = 2'd2;

  // status codes
  localparam stat_t ST_OK    = 2'd0;
  localparam stat_t ST_EMPTY = 2'd1;
  localparam stat_t ST_FULL  = 2'd2;

  // control broadcast to every cell of the chain
  typedef struct packed {
    logic wr;          // load the word at the target position
    logic shift_up;    // cells above the target take their lower neighbor
    logic shift_down;  // every cell takes its upper neighbor
  } cell_ctl_t;

endpackage

// File: rtl/miq_if.sv
interface miq_in_if;
  logic            valid;
  logic            ready;
  miq_pkg::cmd_t   command;
  miq_pkg::data_t  value;

  modport source (output valid, output command, output value, input ready);
  modport sink   (input valid, input command, input value, output ready);
endinterface

interface miq_out_if;
  logic             valid;
  logic             ready;
  miq_pkg::data_t   popped_value;
  miq_pkg::stat_t   status;
  miq_pkg::ecount_t entry_count;

  modport source (output valid, output popped_value, output status, output entry_count,
                  input ready);
  modport sink   (input valid, input popped_value, input status, input entry_count,
                  output ready);
endinterface

// File: rtl/miq_cell.sv
module miq_cell #(
  parameter int unsigned IDX_W = 10,
  parameter int unsigned IDX   = 0
) (
  input  logic               clk,
  input  miq_pkg::cell_ctl_t ctl,
  input  logic [IDX_W-1:0]   pos,
  input  miq_pkg::data_t     value,
  input  miq_pkg::data_t     lower_data,
  input  miq_pkg::data_t     upper_data,
  output miq_pkg::data_t     data
);
  import miq_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  data_t data_r;
  data_t data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (ctl.shift_down) begin
      data_nxt = upper_data;
    end else if (ctl.wr && (pos == MY_IDX)) begin
      data_nxt = value;
    end else if (ctl.shift_up && (MY_IDX > pos)) begin
      data_nxt = lower_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

// File: rtl/middle_insert_queue_unit.sv
// bounded queue of signed 32-bit words with push at tail, insert at middle
// (index ceil(n/2) for n held entries) and pop at head. the queue lives in a
// chain of CAPACITY cells, cell i holding entry i; every command is done by
// all cells at once (hold, load, or take a neighbor's word). an item is
// taken in any cycle in which the result register is free or being drained,
// so the block sustains one item per clock; the result is registered in the
// cycle after the item is taken. each item yields one result with the popped
// word (zero unless a pop succeeded), a status (ok, pop on empty, push or
// insert on full) and the entry count after the item, low 11 bits. command
// code 3 is a no-op reporting ok and the current count. after reset the queue is empty.
module middle_insert_queue_unit #(
  parameter int unsigned CAPACITY = miq_pkg::DEF_CAPACITY
) (
  input  logic      clk,
  input  logic      rst_n,
  miq_in_if.sink    in_chan,
  miq_out_if.source out_chan
);
  import miq_pkg::*;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  // occupancy
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;

  // result register
  logic    out_valid_r;
  data_t   popped_r;
  data_t   popped_nxt;
  stat_t   status_r;
  stat_t   status_nxt;
  ecount_t ecount_r;

  logic             in_acc;
  logic             full;
  logic             empty;
  logic [CNT_W:0]   mid_sum;
  logic [IDX_W-1:0] mid_pos;
  logic [IDX_W-1:0] pos;
  cell_ctl_t        ctl;
  logic [CNT_W+ECOUNT_W-1:0] count_ext;

  data_t cell_data [CAPACITY];

  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign in_acc        = in_chan.valid && in_chan.ready;

  assign full  = (count_r == CAP_CNT);
  assign empty = (count_r == '0);

  // middle slot ceil(n/2); only used when not full, so it fits an index
  assign mid_sum = {1'b0, count_r} + {{CNT_W{1'b0}}, 1'b1};
  assign mid_pos = mid_sum[IDX_W:1];

  // command decode, gated by the handshake
  always_comb begin
    ctl        = '0;
    pos        = count_r[IDX_W-1:0];
    count_nxt  = count_r;
    popped_nxt = '0;
    status_nxt = ST_OK;
    case (in_chan.command)
      CMD_PUSH: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          ctl.wr    = in_acc;
          count_nxt = count_r + 1'b1;
        end
      end
      CMD_INSERT: begin
        pos = mid_pos;
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          ctl.wr       = in_acc;
          ctl.shift_up = in_acc;
          count_nxt    = count_r + 1'b1;
        end
      end
      CMD_POP: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          ctl.shift_down = in_acc;
          popped_nxt     = cell_data[0];
          count_nxt      = count_r - 1'b1;
        end
      end
      default: begin
        // unused code: nothing moves
      end
    endcase
  end

  // the cell chain
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    data_t lower_w;
    data_t upper_w;
    if (i == 0) begin : g_first
      assign lower_w = in_chan.value;
    end else begin : g_lower
      assign lower_w = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign upper_w = cell_data[i];
    end else begin : g_upper
      assign upper_w = cell_data[i+1];
    end

    miq_cell #(
      .IDX_W (IDX_W),
      .IDX   (i)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .pos        (pos),
      .value      (in_chan.value),
      .lower_data (lower_w),
      .upper_data (upper_w),
      .data       (cell_data[i])
    );
  end

  assign count_ext = {{ECOUNT_W{1'b0}}, count_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, no reset
  always_ff @(posedge clk) begin
    if (in_acc) begin
      popped_r <= popped_nxt;
      status_r <= status_nxt;
      ecount_r <= count_ext[ECOUNT_W-1:0];
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.popped_value = popped_r;
  assign out_chan.status       = status_r;
  assign out_chan.entry_count  = ecount_r;

  // occupancy never passes the chain length
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_CNT)
    else $error("queue count above capacity");

  // a taken item always leaves a result waiting
  a_result_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_valid_r)
    else $error("no result after accepted word");

  // pop on an empty queue reports empty and keeps the queue empty
  a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_chan.command == CMD_POP) && empty)
      |=> (status_r == ST_EMPTY) && (count_r == '0) && (popped_r == '0))
    else $error("pop on empty misreported");

  // push or insert when full leaves the count unchanged and reports full
  a_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && ((in_chan.command == CMD_PUSH) || (in_chan.command == CMD_INSERT)) && full)
      |=> (status_r == ST_FULL) && (count_r == CAP_CNT))
    else $error("push on full misreported");

endmodule

// File: tb/sv/tb_middle_insert_queue_unit.sv
module tb_middle_insert_queue_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import miq_pkg::*;

  localparam int unsigned CAPACITY = DEF_CAPACITY;
  // cycles with no word moving on either channel before the run is given up
  localparam int WATCHDOG_LIMIT = 3000;
  // long receiver hold-off used to back the block up into its input
  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_ITEMS = 450;

  // the spare command code, a no-op in the block
  localparam cmd_t CMD_NOP = 2'd3;

  typedef struct {
    data_t   popped_value;
    stat_t   status;
    ecount_t entry_count;
  } queue_result_t;

  logic clk = 1'b0;
  logic rst_n;

  miq_in_if  in_chan ();
  miq_out_if out_chan ();

  middle_insert_queue_unit #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  // queue content as the block should hold it, head at index 0
  data_t         queue_model[$];
  // results predicted for accepted words, oldest first
  queue_result_t pending_results[$];
  queue_result_t oldest_result;

  int fail_count = 0;
  int quiet_cycles = 0;
  // idling switches, one per side, and a pending long hold for the receiver
  bit idle_in = 1'b1;
  bit idle_out = 1'b1;
  int hold_request = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // prediction: the same queue semantics on a plain SV queue
  // push appends, middle insert lands at index ceil(n/2), pop takes the head
  // ---------------------------------------------------------------------------
  task automatic predict_queue_result(cmd_t c, data_t v);
    queue_result_t r;
    int n;
    n = queue_model.size();
    r.popped_value = '0;
    r.status       = ST_OK;
    case (c)
      CMD_PUSH, CMD_INSERT: begin
        if (n >= CAPACITY) begin
          // full: word dropped, nothing changes
          r.status = ST_FULL;
        end else if (c == CMD_PUSH) begin
          queue_model.push_back(v);
        end else begin
          queue_model.insert((n + 1) / 2, v);
        end
      end
      CMD_POP: begin
        if (n == 0) begin
          // empty: report it, popped word stays zero
          r.status = ST_EMPTY;
        end else begin
          r.popped_value = queue_model.pop_front();
        end
      end
      default: begin
        // spare code: ok and current count, no state change
      end
    endcase
    r.entry_count = ecount_t'(queue_model.size());
    pending_results.push_back(r);
  endtask

  // ---------------------------------------------------------------------------
  // sender: optional idle gap, then offer the word until ready is seen
  // valid stays high between back-to-back words
  // ---------------------------------------------------------------------------
  task automatic send_word(cmd_t c, data_t v);
    int gap;
    gap = idle_in ? $urandom_range(0, 13) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_chan.valid = 1'b0;
    end
    @(negedge clk);
    in_chan.valid   = 1'b1;
    in_chan.command = c;
    in_chan.value   = v;
    do @(posedge clk); while (!in_chan.ready);
    predict_queue_result(c, v);
  endtask

  // sender goes quiet until every predicted result has been checked
  task automatic wait_for_results();
    @(negedge clk);
    in_chan.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // values weighted toward the extremes, otherwise uniform over 32 bits
  function automatic data_t pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'sh7fff_ffff;
      1:       return 32'sh8000_0000;
      2:       return '0;
      3:       return '1;
      default: return data_t'($urandom);
    endcase
  endfunction

  function automatic cmd_t pick_store_cmd();
    return ($urandom_range(0, 1) != 0) ? CMD_INSERT : CMD_PUSH;
  endfunction

  // ---------------------------------------------------------------------------
  // receiver: per word stall drawn 0..13, or a long hold when requested
  // ---------------------------------------------------------------------------
  initial begin
    int stall;
    out_chan.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        stall        = hold_request;
        hold_request = 0;
      end else begin
        stall = idle_out ? $urandom_range(0, 13) : 0;
      end
      if (stall > 0) begin
        out_chan.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_chan.ready = 1'b1;
      do @(posedge clk); while (!out_chan.valid);
    end
  end

  // ---------------------------------------------------------------------------
  // checker: every result word against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (pending_results.size() == 0) begin
        $error("result word with no prediction waiting: popped_value %0d status %0d count %0d",
               out_chan.popped_value, out_chan.status, out_chan.entry_count);
        fail_count++;
      end else begin
        oldest_result = pending_results.pop_front();
        if (out_chan.popped_value !== oldest_result.popped_value) begin
          $error("popped_value: expected %0d, actual %0d",
                 oldest_result.popped_value, out_chan.popped_value);
          fail_count++;
        end
        if (out_chan.status !== oldest_result.status) begin
          $error("status: expected %0d, actual %0d", oldest_result.status, out_chan.status);
          fail_count++;
        end
        if (out_chan.entry_count !== oldest_result.entry_count) begin
          $error("entry_count: expected %0d, actual %0d",
                 oldest_result.entry_count, out_chan.entry_count);
          fail_count++;
        end
      end
    end
  end

  // watchdog: any accepted word on either side restarts the count
  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // extremes, every command, empty pop and the spare code
  task automatic test_directed();
    send_word(CMD_POP, 32'sh1234_5678);     // pop on empty
    send_word(CMD_NOP, 32'sh7fff_ffff);     // spare code on empty
    send_word(CMD_INSERT, 32'sh8000_0000);  // middle insert into empty queue
    send_word(CMD_PUSH, 32'sh7fff_ffff);
    send_word(CMD_INSERT, '0);              // even count, lands at front tail
    send_word(CMD_INSERT, '1);              // odd count, lands at back head
    send_word(CMD_PUSH, 32'sh5555_5555);
    send_word(CMD_PUSH, 32'shaaaa_aaaa);
    send_word(CMD_NOP, 32'shffff_ffff);
    send_word(CMD_POP, 32'sh7fff_ffff);
    send_word(CMD_INSERT, 32'sh0000_0001);
    send_word(CMD_POP, '0);
    send_word(CMD_POP, '0);
    send_word(CMD_PUSH, 32'sh8000_0001);
    send_word(CMD_POP, '1);
    send_word(CMD_POP, '0);
    send_word(CMD_POP, '0);
    send_word(CMD_POP, '0);
    send_word(CMD_POP, '0);                 // drained, now empty again
    send_word(CMD_POP, 32'shdead_beef);     // second empty pop
    send_word(CMD_PUSH, 32'shffff_fffe);
    send_word(CMD_POP, '0);
    wait_for_results();
  endtask

  // random mix in stretches biased toward growing, shrinking or holding level
  task automatic test_random_mix(int n_items);
    int mode;
    int roll;
    int store_pct;
    cmd_t c;
    for (int i = 0; i < n_items; i++) begin
      if (i % 40 == 0) begin
        mode     = $urandom_range(0, 2);
        idle_in  = ($urandom_range(0, 3) != 0);
        idle_out = ($urandom_range(0, 3) != 0);
      end
      store_pct = (mode == 0) ? 65 : (mode == 1) ? 30 : 50;
      roll = $urandom_range(0, 99);
      if (roll < 4) begin
        c = CMD_NOP;
      end else if (roll < 4 + store_pct) begin
        c = pick_store_cmd();
      end else begin
        c = CMD_POP;
      end
      send_word(c, pick_value());
    end
    idle_in  = 1'b1;
    idle_out = 1'b1;
  endtask

  // receiver holds off long while the sender keeps offering back to back
  task automatic test_backpressure();
    idle_in      = 1'b0;
    hold_request = HOLD_CYCLES;
    for (int i = 0; i < 30; i++) begin
      send_word((i % 3 == 2) ? CMD_POP : pick_store_cmd(), pick_value());
    end
    idle_in = 1'b1;
    // sender pauses until everything has come back
    wait_for_results();
  endtask

  // fill to capacity, hit the full case, then drain past empty
  task automatic test_fill_and_drain();
    while (queue_model.size() < CAPACITY) begin
      send_word(pick_store_cmd(), pick_value());
    end
    send_word(CMD_PUSH, pick_value());      // push on full
    send_word(CMD_INSERT, pick_value());    // middle insert on full
    send_word(CMD_NOP, pick_value());
    send_word(CMD_POP, pick_value());       // one below full
    send_word(CMD_INSERT, pick_value());    // back to full
    send_word(CMD_PUSH, pick_value());      // full again
    send_word(CMD_POP, pick_value());
    send_word(CMD_PUSH, pick_value());
    while (queue_model.size() > 0) begin
      send_word(CMD_POP, pick_value());
    end
    send_word(CMD_POP, pick_value());       // empty after full drain
    wait_for_results();
  endtask

  initial begin
    rst_n           = 1'b0;
    in_chan.valid   = 1'b0;
    in_chan.command = CMD_PUSH;
    in_chan.value   = '0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_random_mix(RANDOM_ITEMS);
    test_backpressure();
    test_fill_and_drain();
    test_random_mix(60);

    // stimulus done: drain, then idle on to catch stray words
    wait_for_results();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
